FILE: rtl/core/hrfc_pkg.sv
// Package for the report frame checker core: codes, widths and the structs
// that pass between its modules. No dependencies.
`default_nettype none

package hrfc_pkg;

	localparam int RING_SIZE = 1024;
	localparam int RING_AW   = $clog2(RING_SIZE);
	localparam int TAIL_W    = 10;
	localparam int IDX_W     = 10;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 7;
	localparam int SUM_W     = 16;
	localparam int QDEPTH    = 3;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd61;
	localparam logic [POS_W-1:0]  POS_MAX     = 7'd127;

	localparam logic ACT_PKT  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_BUSY    = 3'd0,
		ST_ACCEPT  = 3'd1,
		ST_SUM_ERR = 3'd2,
		ST_LEN_ERR = 3'd3,
		ST_SHORT   = 3'd4,
		ST_IGNORED = 3'd5
	} status_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
		logic [BYTE_W-1:0]  data;
	} ring_wr_t;

	typedef struct packed {
		logic               en;
		logic [RING_AW-1:0] addr;
	} ring_rd_t;

	typedef struct packed {
		status_t            status;
		logic [RING_AW-1:0] tail;
		logic               is_read;
	} res_t;

	typedef struct packed {
		status_t            status;
		logic [TAIL_W-1:0]  tail;
		logic [BYTE_W-1:0]  data;
	} entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/hrfc_in_if.sv
// Input channel of the frame checker: valid/ready plus one packet or read item.
// Depends on hrfc_pkg for field widths.
`default_nettype none

interface hrfc_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [hrfc_pkg::BYTE_W-1:0]   data_byte;
	logic                          end_of_packet;
	logic [hrfc_pkg::IDX_W-1:0]    read_index;

	modport source (output valid, action, data_byte, end_of_packet, read_index, input ready);
	modport sink   (input valid, action, data_byte, end_of_packet, read_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hrfc_out_if.sv
// Result channel of the frame checker: valid/ready plus status, tail and read data.
// Depends on hrfc_pkg for field widths.
`default_nettype none

interface hrfc_out_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [hrfc_pkg::TAIL_W-1:0]   tail_position;
	logic [hrfc_pkg::BYTE_W-1:0]   read_data;

	modport source (output valid, status, tail_position, read_data, input ready);
	modport sink   (input valid, status, tail_position, read_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hid_report_frame_checker_core.sv
// Channel   Dir  Handshake     Payload
// item      in   valid/ready   action, data_byte, end_of_packet, read_index
// result    out  valid/ready   status, tail_position, read_data
//
// One transaction per cycle sustained while the result side keeps up; each
// result is registered with the ring memory read, then written into the result queue.
// The ring is one 1024x8 memory with one write and one read port; packet bytes
// write it, read actions read it, so no port conflict arises.
// Reset clears tail and packet state; the ring contents stay undefined.
// A stalled result side fills the three-entry queue, then drops item ready.
`default_nettype none

module hid_report_frame_checker_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hrfc_in_if.sink    item,
	hrfc_out_if.source result
);
	import hrfc_pkg::*;

	ring_wr_t            ring_wr;
	ring_rd_t            ring_rd;
	logic                valid_s1;
	res_t                res_s1;
	logic [BYTE_W-1:0]   ring_data;
	logic                credit;
	logic                accept;

	assign item.ready = credit;
	assign accept     = item.valid && credit;

	hrfc_frame_ctl u_ctl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.action        (item.action),
		.data_byte     (item.data_byte),
		.end_of_packet (item.end_of_packet),
		.read_index    (item.read_index),
		.ring_wr       (ring_wr),
		.ring_rd       (ring_rd),
		.valid_s1      (valid_s1),
		.res_s1        (res_s1)
	);

	hrfc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (ring_wr.en),
		.waddr (ring_wr.addr),
		.wdata (ring_wr.data),
		.re    (ring_rd.en),
		.raddr (ring_rd.addr),
		.rdata (ring_data)
	);

	hrfc_rsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.res_s1    (res_s1),
		.ring_data (ring_data),
		.credit    (credit),
		.result    (result)
	);
endmodule

`default_nettype wire

FILE: rtl/core/hrfc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module hrfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

FILE: rtl/core/hrfc_frame_ctl.sv
// Packet parser: tracks length, running sum and checksum, issues ring writes
// and reads, and registers the per-item result. Uses hrfc_pkg.
`default_nettype none

module hrfc_frame_ctl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           accept,
	input  wire logic                           action,
	input  wire logic [hrfc_pkg::BYTE_W-1:0]    data_byte,
	input  wire logic                           end_of_packet,
	input  wire logic [hrfc_pkg::IDX_W-1:0]     read_index,
	output      hrfc_pkg::ring_wr_t             ring_wr,
	output      hrfc_pkg::ring_rd_t             ring_rd,
	output      logic                           valid_s1,
	output      hrfc_pkg::res_t                 res_s1
);
	import hrfc_pkg::*;

	logic [RING_AW-1:0] tail_q, tail_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [BYTE_W-1:0]  len_q, len_d;
	logic [SUM_W-1:0]   sum_q, sum_d;
	logic [SUM_W-1:0]   chk_q, chk_d;
	logic [8:0]         pos9;
	logic [8:0]         len9;
	logic [8:0]         lenn9;
	logic               is_pkt;
	status_t            status;

	assign is_pkt = accept && (action == ACT_PKT);
	assign pos9   = {2'b00, pos_q};
	assign len9   = {1'b0, len_q};
	assign lenn9  = {1'b0, len_d};

	always_comb begin
		len_d        = len_q;
		sum_d        = sum_q;
		chk_d        = chk_q;
		tail_d       = tail_q;
		status       = ST_BUSY;
		ring_wr.en   = 1'b0;
		ring_wr.addr = tail_q + RING_AW'(pos_q) - RING_AW'(1);
		ring_wr.data = data_byte;

		if (pos_q == '0) begin
			len_d = data_byte;
			sum_d = '0;
			chk_d = '0;
		end else if (pos9 <= len9) begin
			if (len_q <= MAX_PAYLOAD) begin
				ring_wr.en = is_pkt;
				sum_d      = sum_q + SUM_W'(data_byte);
			end
		end else if (pos9 == len9 + 9'd1) begin
			chk_d = {data_byte, 8'h00};
		end else if (pos9 == len9 + 9'd2) begin
			chk_d = chk_q | SUM_W'(data_byte);
		end

		if (end_of_packet) begin
			if (pos_q == '0) begin
				status = ST_IGNORED;
			end else if (len_d > MAX_PAYLOAD) begin
				status = ST_LEN_ERR;
			end else if (pos9 < lenn9 + 9'd2) begin
				status = ST_SHORT;
			end else if (sum_d == chk_d) begin
				status = ST_ACCEPT;
				tail_d = tail_q + RING_AW'(len_d);
			end else begin
				status = ST_SUM_ERR;
			end
		end

		if (end_of_packet) begin
			pos_d = '0;
		end else if (pos_q < POS_MAX) begin
			pos_d = pos_q + POS_W'(1);
		end else begin
			pos_d = pos_q;
		end
	end

	assign ring_rd.en   = accept && (action == ACT_READ);
	assign ring_rd.addr = read_index[RING_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q   <= '0;
			pos_q    <= '0;
			len_q    <= '0;
			sum_q    <= '0;
			chk_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (is_pkt) begin
				tail_q <= tail_d;
				pos_q  <= pos_d;
				len_q  <= len_d;
				sum_q  <= sum_d;
				chk_q  <= chk_d;
			end
		end
	end

	// result fields are registered alongside the ring read data
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.is_read <= (action == ACT_READ);
			res_s1.status  <= (action == ACT_READ) ? ST_BUSY : status;
			res_s1.tail    <= (action == ACT_READ) ? tail_q : tail_d;
		end
	end
endmodule

`default_nettype wire

FILE: rtl/core/hrfc_rsp_queue.sv
// Three-entry result queue that decouples the output handshake from the
// ring pipeline and grants input credit. Uses hrfc_pkg and hrfc_out_if.
`default_nettype none

module hrfc_rsp_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire hrfc_pkg::res_t              res_s1,
	input  wire logic [hrfc_pkg::BYTE_W-1:0] ring_data,
	output      logic                        credit,
	hrfc_out_if.source                       result
);
	import hrfc_pkg::*;

	entry_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;
	entry_t              head;
	entry_t              new_entry;
	logic [QCNT_W:0]     used;

	assign pop    = result.valid && result.ready;
	assign head   = q_mem_q[rd_ptr_q];

	assign result.valid         = (cnt_q != '0);
	assign result.status        = head.status;
	assign result.tail_position = head.tail;
	assign result.read_data     = head.data;

	// count the transaction still in the ring stage against free slots
	assign used   = {1'b0, cnt_q} + (QCNT_W + 1)'(push);
	assign credit = used < (QCNT_W + 1)'(QDEPTH);

	always_comb begin
		new_entry.status = res_s1.status;
		new_entry.tail   = TAIL_W'(res_s1.tail);
		new_entry.data   = res_s1.is_read ? ring_data : '0;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end
endmodule

`default_nettype wire
